// ----- hdl/pn3_pkg.sv -----
// Shared 3D gradient noise constants: permutation ROM, gradient codes, output limits.
package pn3_pkg;

    localparam int PERM_ENTRIES = 256;
    localparam int CELL_BITS    = 8;

    // Gradient selection codes
    localparam logic [3:0] GRAD_U_LIMIT = 4'd8;
    localparam logic [3:0] GRAD_V_LIMIT = 4'd4;
    localparam logic [3:0] GRAD_XY_POS  = 4'd12;
    localparam logic [3:0] GRAD_XY_NEG  = 4'd13;

    // Output saturation limits (18-bit signed)
    localparam int OUT_BITS = 18;
    localparam int OUT_MAX  = 131071;
    localparam int OUT_MIN  = -131072;

    localparam logic [7:0] PERM_ROM [PERM_ENTRIES] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,  8'd201, 8'd95,
        8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225, 8'd140, 8'd36,  8'd103, 8'd30,
        8'd69,  8'd142, 8'd8,   8'd99,  8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190,
        8'd6,   8'd148, 8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,  8'd57,  8'd177,
        8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,  8'd174, 8'd20,  8'd125, 8'd136,
        8'd171, 8'd168, 8'd68,  8'd175, 8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,
        8'd27,  8'd166, 8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,  8'd55,  8'd46,
        8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,  8'd161,
        8'd1,   8'd216, 8'd80,  8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,
        8'd18,  8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217,
        8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126,
        8'd255, 8'd82,  8'd85,  8'd212, 8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,
        8'd58,  8'd17,  8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,  8'd221, 8'd153,
        8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,   8'd129, 8'd22,  8'd39,  8'd253,
        8'd19,  8'd98,  8'd108, 8'd110, 8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
        8'd112, 8'd104, 8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241, 8'd81,  8'd51,
        8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107, 8'd49,  8'd192, 8'd214, 8'd31,
        8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121,
        8'd50,  8'd45,  8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141, 8'd128, 8'd195,
        8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

endpackage

// ----- hdl/pn3_hash.sv -----
// Three-stage permutation hash chain producing the 4-bit gradient code of all eight corners.
module pn3_hash
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] cell_x,
    input  logic [7:0] cell_y,
    input  logic [7:0] cell_z,
    output logic [3:0] code [8]
);

    logic [7:0] px_reg [2];
    logic [7:0] iy1_reg;
    logic [7:0] iz1_reg;
    logic [7:0] hy_reg [4];
    logic [7:0] iz2_reg;
    logic [3:0] h_reg  [8];

    logic [7:0] hy_next [4];
    logic [3:0] h_next  [8];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            hy_next[k] = pn3_pkg::PERM_ROM[8'(px_reg[k % 2] + iy1_reg + 8'(k / 2))];
        end
        for (int k = 0; k < 8; k++)
        begin
            h_next[k] = pn3_pkg::PERM_ROM[8'(hy_reg[k % 4] + iz2_reg + 8'(k / 4))][3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= pn3_pkg::PERM_ROM[cell_x];
            px_reg[1] <= pn3_pkg::PERM_ROM[8'(cell_x + 8'd1)];
            iy1_reg   <= cell_y;
            iz1_reg   <= cell_z;
            hy_reg    <= hy_next;
            iz2_reg   <= iz1_reg;
            h_reg     <= h_next;
        end
    end

    assign code = h_reg;

endmodule

// ----- hdl/pn3_fade.sv -----
// Four-stage fade curve 6t^5-15t^4+10t^3 with rounding after every product.
module pn3_fade
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [FRAC_BITS-1:0]       t,
    output logic signed [FRAC_BITS+4:0] w
);

    localparam int AW = FRAC_BITS + 5;
    localparam int PW = 2 * AW;
    localparam logic signed [AW-1:0] FIFTEEN = AW'(15) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] TEN     = AW'(10) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [AW-1:0] t_in;
    logic signed [AW-1:0] t1_reg, a1_reg;
    logic signed [AW-1:0] t2x_reg, b2_reg, sq2_reg;
    logic signed [AW-1:0] c3_reg, cu3_reg;
    logic signed [AW-1:0] w4_reg;
    logic signed [PW-1:0] p_ta, p_tt, p_cu, p_w;

    assign t_in = $signed({5'b0, t});

    always_comb
    begin
        p_ta = PW'(t1_reg) * PW'(a1_reg);
        p_tt = PW'(t1_reg) * PW'(t1_reg);
        p_cu = PW'(sq2_reg) * PW'(t2x_reg);
        p_w  = PW'(cu3_reg) * PW'(c3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t_in;
            a1_reg  <= (t_in <<< 2) + (t_in <<< 1) - FIFTEEN;
            t2x_reg <= t1_reg;
            b2_reg  <= AW'((p_ta + HALF) >>> FRAC_BITS);
            sq2_reg <= AW'((p_tt + HALF) >>> FRAC_BITS);
            c3_reg  <= b2_reg + TEN;
            cu3_reg <= AW'((p_cu + HALF) >>> FRAC_BITS);
            w4_reg  <= AW'((p_w + HALF) >>> FRAC_BITS);
        end
    end

    assign w = w4_reg;

endmodule

// ----- hdl/pn3_grad.sv -----
// One corner gradient: signed sum of two corner offsets picked by the hash code, registered.
module pn3_grad
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [3:0]                  code,
    input  logic signed [FRAC_BITS+1:0] ox,
    input  logic signed [FRAC_BITS+1:0] oy,
    input  logic signed [FRAC_BITS+1:0] oz,
    output logic signed [FRAC_BITS+4:0] grad
);

    localparam int VW = FRAC_BITS + 5;

    logic                 xy_pair;
    logic signed [VW-1:0] u, v, su, sv;
    logic signed [VW-1:0] grad_reg;

    always_comb
    begin
        xy_pair = (code == pn3_pkg::GRAD_XY_POS) || (code == pn3_pkg::GRAD_XY_NEG);
        u  = (code < pn3_pkg::GRAD_U_LIMIT || xy_pair) ? VW'(ox) : VW'(oy);
        v  = (code < pn3_pkg::GRAD_V_LIMIT || xy_pair) ? VW'(oy) : VW'(oz);
        su = code[0] ? -u : u;
        sv = code[1] ? -v : v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grad_reg <= su + sv;
        end
    end

    assign grad = grad_reg;

endmodule

// ----- hdl/pn3_lerp.sv -----
// One registered interpolation step: lo + round(w * (hi - lo)).
module pn3_lerp
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [FRAC_BITS+4:0] w,
    input  logic signed [FRAC_BITS+4:0] lo,
    input  logic signed [FRAC_BITS+4:0] hi,
    output logic signed [FRAC_BITS+4:0] res
);

    localparam int VW = FRAC_BITS + 5;
    localparam int DW = VW + 1;
    localparam int PW = DW + VW;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [VW-1:0] res_reg;

    always_comb
    begin
        diff = DW'(hi) - DW'(lo);
        prod = PW'(w) * PW'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= lo + VW'((prod + HALF) >>> FRAC_BITS);
        end
    end

    assign res = res_reg;

endmodule

// ----- hdl/perlin_noise_3d.sv -----
// Top level of the 3D improved gradient noise pipeline.
//
// Input channel: coord_x/y/z with in_valid; a transfer happens when in_valid is
// high and in_stall is low. Coordinates are signed fixed point with FRAC_BITS
// fraction bits; the cell index wraps modulo 256.
// Output channel: noise_value with out_valid; a transfer happens when out_valid
// is high and out_stall is low. The result is saturated to 18 bits signed.
// From input transfer to out_valid there are three hash ROM stages, one
// gradient stage and three interpolation stages, with the fade curve computed
// alongside in four stages. One point is taken every cycle while the pipeline
// is not held. All stages move together; only a full output register held by
// out_stall stops the pipeline, and then in_stall is raised in the same cycle.
// Bubbles stop with the rest, so a stall loses and repeats nothing.
// Reset clears all valid bits; the pipeline is empty afterwards.
module perlin_noise_3d
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] noise_value
);

    localparam int VW     = FRAC_BITS + 5;
    localparam int OW     = FRAC_BITS + 2;
    localparam int STAGES = 7;
    localparam int SW     = (VW > pn3_pkg::OUT_BITS) ? VW : pn3_pkg::OUT_BITS;
    localparam logic signed [OW-1:0] ONE  = OW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] SMAX = SW'(pn3_pkg::OUT_MAX);
    localparam logic signed [SW-1:0] SMIN = SW'(pn3_pkg::OUT_MIN);

    logic                 adv;
    logic [STAGES-1:0]    vld_reg;

    logic [FRAC_BITS-1:0] fx_reg [3];
    logic [FRAC_BITS-1:0] fy_reg [3];
    logic [FRAC_BITS-1:0] fz_reg [3];

    logic [3:0]           code [8];
    logic signed [OW-1:0] dxo, dyo, dzo, exo, eyo, ezo;
    logic signed [VW-1:0] grad [8];
    logic signed [VW-1:0] wx, wy, wz;
    logic signed [VW-1:0] wy5_reg, wz5_reg, wz6_reg;
    logic signed [VW-1:0] xl [4];
    logic signed [VW-1:0] yl [2];
    logic signed [VW-1:0] rl;
    logic signed [SW-1:0] r_ext;

    assign adv      = !(vld_reg[STAGES-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // Fraction delay line for the gradient stage; fade weight delays for y and z
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_reg[0] <= coord_x[FRAC_BITS-1:0];
            fy_reg[0] <= coord_y[FRAC_BITS-1:0];
            fz_reg[0] <= coord_z[FRAC_BITS-1:0];
            for (int k = 1; k < 3; k++)
            begin
                fx_reg[k] <= fx_reg[k-1];
                fy_reg[k] <= fy_reg[k-1];
                fz_reg[k] <= fz_reg[k-1];
            end
            wy5_reg <= wy;
            wz5_reg <= wz;
            wz6_reg <= wz5_reg;
        end
    end

    pn3_hash u_hash
    (
        .clk    (clk),
        .en     (adv),
        .cell_x (coord_x[FRAC_BITS+7:FRAC_BITS]),
        .cell_y (coord_y[FRAC_BITS+7:FRAC_BITS]),
        .cell_z (coord_z[FRAC_BITS+7:FRAC_BITS]),
        .code   (code)
    );

    pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x
        (.clk(clk), .en(adv), .t(coord_x[FRAC_BITS-1:0]), .w(wx));
    pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y
        (.clk(clk), .en(adv), .t(coord_y[FRAC_BITS-1:0]), .w(wy));
    pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z
        (.clk(clk), .en(adv), .t(coord_z[FRAC_BITS-1:0]), .w(wz));

    always_comb
    begin
        dxo = $signed({2'b0, fx_reg[2]});
        dyo = $signed({2'b0, fy_reg[2]});
        dzo = $signed({2'b0, fz_reg[2]});
        exo = dxo - ONE;
        eyo = dyo - ONE;
        ezo = dzo - ONE;
    end

    // Corner k has x offset bit 0 of k, y bit 1, z bit 2
    for (genvar k = 0; k < 8; k++)
    begin : g_corner
        pn3_grad #(.FRAC_BITS(FRAC_BITS)) u_grad
        (
            .clk  (clk),
            .en   (adv),
            .code (code[k]),
            .ox   (((k & 1) != 0) ? exo : dxo),
            .oy   (((k & 2) != 0) ? eyo : dyo),
            .oz   (((k & 4) != 0) ? ezo : dzo),
            .grad (grad[k])
        );
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lerp_x
        pn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp
            (.clk(clk), .en(adv), .w(wx), .lo(grad[2*k]), .hi(grad[2*k+1]), .res(xl[k]));
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_lerp_y
        pn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp
            (.clk(clk), .en(adv), .w(wy5_reg), .lo(xl[2*k]), .hi(xl[2*k+1]), .res(yl[k]));
    end

    pn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z
        (.clk(clk), .en(adv), .w(wz6_reg), .lo(yl[0]), .hi(yl[1]), .res(rl));

    always_comb
    begin
        r_ext = SW'(rl);
        if (r_ext > SMAX)
        begin
            r_ext = SMAX;
        end
        else if (r_ext < SMIN)
        begin
            r_ext = SMIN;
        end
        noise_value = r_ext[pn3_pkg::OUT_BITS-1:0];
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted point did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved while the pipeline was held");

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[STAGES-2] && adv) |=> out_valid)
        else $error("point lost before the output register");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the 3D gradient noise pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC    = 16;
    localparam int LATENCY = 7;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int NUM_RANDOM = 1530;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [17:0] noise_value;

    perlin_noise_3d #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 clk = ~clk;

    point_t      point_queue[$];
    logic [17:0] noise_expected[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_off = 0;
    bit  sender_pause = 1'b0;
    bit  stim_done = 1'b0;

    // round half up, then floor shift
    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (64'sd1 << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint smooth(longint t);
        longint c, t2, t3;
        c  = fx_mul(t, 6 * t - 15 * ONE) + 10 * ONE;
        t2 = fx_mul(t, t);
        t3 = fx_mul(t2, t);
        return fx_mul(t3, c);
    endfunction

    function automatic longint grad_dot(int cx, int cy, int cz,
                                        longint ox, longint oy, longint oz);
        logic [7:0] h8;
        logic [3:0] h;
        longint u, v;
        h8 = pn3_pkg::PERM_ROM[(pn3_pkg::PERM_ROM[(pn3_pkg::PERM_ROM[cx & 255] + cy) & 255]
                                + cz) & 255];
        h  = h8[3:0];
        u  = (h < pn3_pkg::GRAD_U_LIMIT || h == pn3_pkg::GRAD_XY_POS
              || h == pn3_pkg::GRAD_XY_NEG) ? ox : oy;
        v  = (h < pn3_pkg::GRAD_V_LIMIT || h == pn3_pkg::GRAD_XY_POS
              || h == pn3_pkg::GRAD_XY_NEG) ? oy : oz;
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic longint blend(longint w, longint lo, longint hi);
        return lo + fx_mul(w, hi - lo);
    endfunction

    function automatic logic [17:0] noise_at(point_t p);
        int ix, iy, iz;
        longint dx, dy, dz, ex, ey, ez, wx, wy, wz, x00, x10, x01, x11, y0, y1, r;
        ix = (p.x >> FRAC) & 255;
        iy = (p.y >> FRAC) & 255;
        iz = (p.z >> FRAC) & 255;
        dx = longint'(p.x[FRAC-1:0]);
        dy = longint'(p.y[FRAC-1:0]);
        dz = longint'(p.z[FRAC-1:0]);
        ex = dx - ONE; ey = dy - ONE; ez = dz - ONE;
        wx = smooth(dx); wy = smooth(dy); wz = smooth(dz);
        x00 = blend(wx, grad_dot(ix, iy, iz, dx, dy, dz),
                    grad_dot(ix + 1, iy, iz, ex, dy, dz));
        x10 = blend(wx, grad_dot(ix, iy + 1, iz, dx, ey, dz),
                    grad_dot(ix + 1, iy + 1, iz, ex, ey, dz));
        x01 = blend(wx, grad_dot(ix, iy, iz + 1, dx, dy, ez),
                    grad_dot(ix + 1, iy, iz + 1, ex, dy, ez));
        x11 = blend(wx, grad_dot(ix, iy + 1, iz + 1, dx, ey, ez),
                    grad_dot(ix + 1, iy + 1, iz + 1, ex, ey, ez));
        y0 = blend(wy, x00, x10);
        y1 = blend(wy, x01, x11);
        r  = blend(wz, y0, y1);
        if (r > pn3_pkg::OUT_MAX) r = pn3_pkg::OUT_MAX;
        if (r < pn3_pkg::OUT_MIN) r = pn3_pkg::OUT_MIN;
        return r[17:0];
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h00FF,
                       16'($urandom())};
            2: return {16'($urandom_range(0, 511) - 256), 16'($urandom())};
            3: return {16'($urandom()), $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF};
            4: return {16'($urandom()), 16'($urandom_range(0, 3) << 14)};
            default: return {16'($urandom_range(0, 7)), 16'($urandom())};
        endcase
    endfunction

    // feed the DUT from the queue, advance on transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                noise_expected.push_back(noise_at({coord_x, coord_y, coord_z}));
                point_queue.pop_front();
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            end
            if ((!in_valid || !in_stall) && !sender_pause)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (point_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    coord_x  <= point_queue[0].x;
                    coord_y  <= point_queue[0].y;
                    coord_z  <= point_queue[0].z;
                end
                else
                    in_valid <= 1'b0;
            end
            else if (sender_pause && !(in_valid && in_stall))
                in_valid <= 1'b0;
        end
    end

    // receiver: check each transfer, draw stalls
    always @(posedge clk)
    begin
        logic [17:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (noise_expected.size() == 0)
                begin
                    $display("%0t: unexpected noise_value %0d", $time, noise_value);
                    errors++;
                end
                else
                begin
                    want = noise_expected.pop_front();
                    if (want !== noise_value)
                    begin
                        $display("%0t: noise_value expected %0d actual %0d", $time,
                                 $signed(want), noise_value);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        point_t p;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // extremes, cell wrap, fraction edges
        point_queue.push_back('{32'h0, 32'h0, 32'h0});
        point_queue.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        point_queue.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
        point_queue.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        point_queue.push_back('{32'h00FF8000, 32'h00FFFFFF, 32'h00FF0001});
        point_queue.push_back('{32'h80007FFF, 32'h7FFF8000, 32'h00010000});
        point_queue.push_back('{32'hFFFF0000, 32'h0000FFFF, 32'hAAAA5555});
        point_queue.push_back('{32'h55558000, 32'hAAAA4000, 32'h0000C000});
        // walk cells so every gradient code comes up
        for (int i = 0; i < 16; i++)
            point_queue.push_back('{i << 16 | 32'h5A5A, (i * 7) << 16 | 32'hC3C3,
                                   (i * 13) << 16 | 32'h3C3C});
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == 500)
            begin
                wait (point_queue.size() == 0);
                @(posedge clk);
                hold_off = 120;
            end
            if (i == 1000)
            begin
                wait (point_queue.size() == 0);
                sender_pause = 1'b1;
                wait (noise_expected.size() == 0 && !in_valid);
                repeat (LATENCY + 2) @(posedge clk);
                sender_pause = 1'b0;
            end
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            point_queue.push_back(p);
        end
        wait (point_queue.size() == 0);
        wait (noise_expected.size() == 0);
        repeat (LATENCY * 4) @(posedge clk);
        if (errors == 0 && noise_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/pn3_pkg.sv
hdl/pn3_hash.sv
hdl/pn3_fade.sv
hdl/pn3_grad.sv
hdl/pn3_lerp.sv
hdl/perlin_noise_3d.sv
dv/testbench.sv
